>>> rtl/sliding_trimmed_mean_filter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding trimmed mean filter
// Property wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SLIDING_TRIMMED_MEAN_FILTER_MACROS_SVH
`define SLIDING_TRIMMED_MEAN_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent holds in the same cycle as the antecedent.
`define STMF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define STMF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STMF_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define STMF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/stmf_pkg.sv
// ----------------------------------------------------------------------------
// Sliding trimmed mean filter package
// Window geometry, data types and the output saturation function.
// ----------------------------------------------------------------------------
package stmf_pkg;

    localparam int WINDOW_SIZE = 16;
    localparam int TRIM_COUNT  = 4;

    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 19;
    localparam int IDX_W    = $clog2(WINDOW_SIZE);
    localparam int ACC_W    = SAMPLE_W + IDX_W;

    // Ranks from KEEP_LO up to KEEP_HI - 1 survive trimming.
    localparam int KEEP_LO = TRIM_COUNT;
    localparam int KEEP_HI = WINDOW_SIZE - TRIM_COUNT;

    localparam int SUM_MAX = 262143;
    localparam int SUM_MIN = -262144;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [OUT_W-1:0]    out_sum_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [IDX_W-1:0]           idx_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic shift;       // push a new word, everything moves one place older
        logic fill;        // first word after reset: every cell takes it
        logic load_probe;  // copy own value into the probe and clear the rank
        logic count;       // compare probe against value, bump the rank
        logic rotate;      // pass the probe one cell toward index zero
        logic load_masked; // load the probe with the kept value or zero
        idx_t step;        // rotation step during ranking
    } cell_ctrl_t;

    function automatic out_sum_t saturate(input acc_t value);
        acc_t hi;
        acc_t lo;
        hi = ACC_W'(SUM_MAX);
        lo = ACC_W'(SUM_MIN);
        if (value > hi) begin
            return OUT_W'(hi);
        end else if (value < lo) begin
            return OUT_W'(lo);
        end else begin
            return OUT_W'(value);
        end
    endfunction

endpackage

>>> rtl/stmf_cell.sv
// ----------------------------------------------------------------------------
// Sliding trimmed mean filter cell
// Holds one window entry, counts its rank against a rotating probe and
// hands its probe to the neighbor on every rotation step.
// ----------------------------------------------------------------------------
module stmf_cell (
    input  logic                 aclk,
    input  stmf_pkg::cell_ctrl_t ctrl,
    input  stmf_pkg::idx_t       cell_idx,
    input  stmf_pkg::sample_t    sample_in,
    input  stmf_pkg::sample_t    shift_in,
    input  stmf_pkg::sample_t    probe_in,
    output stmf_pkg::sample_t    value_out,
    output stmf_pkg::sample_t    probe_out
);
    import stmf_pkg::*;

    sample_t value_reg;
    sample_t value_next;
    sample_t probe_reg;
    sample_t probe_next;
    idx_t    rank_reg;
    idx_t    rank_next;
    logic    tie_ahead;
    logic    ahead;
    logic    kept;

    // At rotation step t the probe carries entry (index + t) mod size, which
    // is older than this cell exactly when index + t wraps past the end.
    assign tie_ahead = (int'(ctrl.step) + int'(cell_idx)) >= WINDOW_SIZE;
    assign ahead     = (probe_reg < value_reg) || ((probe_reg == value_reg) && tie_ahead);
    assign kept      = (int'(rank_reg) >= KEEP_LO) && (int'(rank_reg) < KEEP_HI);

    always_comb begin
        value_next = value_reg;
        if (ctrl.fill) begin
            value_next = sample_in;
        end else if (ctrl.shift) begin
            value_next = shift_in;
        end
    end

    always_comb begin
        probe_next = probe_reg;
        rank_next  = rank_reg;
        if (ctrl.load_probe) begin
            probe_next = value_reg;
            rank_next  = '0;
        end else if (ctrl.load_masked) begin
            probe_next = kept ? value_reg : '0;
        end else begin
            if (ctrl.count) begin
                rank_next = rank_reg + IDX_W'(ahead);
            end
            if (ctrl.rotate) begin
                probe_next = probe_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        probe_reg <= probe_next;
        rank_reg  <= rank_next;
    end

    assign value_out = value_reg;
    assign probe_out = probe_reg;

endmodule

>>> rtl/sliding_trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// Sliding trimmed mean filter
// Sum of the middle entries of a sliding window of signed samples.
// ----------------------------------------------------------------------------
// Each input word is one signed 16-bit sample, pushed into a 16-entry window
// (the first sample after reset fills the whole window). The block drops the
// 4 largest and 4 smallest entries and returns the sum of the other 8, which
// is the trimmed mean times eight, saturated to 19 bits. The window lives in
// a row of cells; a probe copy of the window rotates once around the row so
// that every cell counts its rank, then rotates again to add up the kept
// entries. A new sample is accepted only after both rotations for the last one
// are through and its sum has gone to the output register. The result waits
// there, so the next sample is taken while that result is still pending.
module sliding_trimmed_mean_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [18:0] trimmed_sum, [23:19] zero
);
    import stmf_pkg::*;

    `include "sliding_trimmed_mean_filter_macros.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_RANK = 3'd2;
    localparam logic [2:0] ST_MASK = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    idx_t       cnt_reg;
    idx_t       cnt_next;
    logic       primed_reg;
    logic       primed_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_sum_t   out_data_reg;
    out_sum_t   out_data_next;
    acc_t       acc_reg;
    acc_t       acc_next;

    logic       s_accept;
    logic       cnt_last;
    logic       out_free;
    cell_ctrl_t ctrl;
    sample_t    sample_in;
    sample_t    cell_value [WINDOW_SIZE];
    sample_t    cell_probe [WINDOW_SIZE];

    assign sample_in = s_tdata;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cnt_last  = (cnt_reg == IDX_W'(WINDOW_SIZE - 1));
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        ctrl             = '0;
        ctrl.fill        = s_accept && !primed_reg;
        ctrl.shift       = s_accept && primed_reg;
        ctrl.load_probe  = (state_reg == ST_LOAD);
        ctrl.count       = (state_reg == ST_RANK);
        ctrl.rotate      = (state_reg == ST_RANK) || (state_reg == ST_SUM);
        ctrl.load_masked = (state_reg == ST_MASK);
        ctrl.step        = cnt_reg;
    end

    genvar g;
    generate
        for (g = 0; g < WINDOW_SIZE; g++) begin : g_cell
            sample_t shift_src;
            if (g == WINDOW_SIZE - 1) begin : g_tail
                assign shift_src = sample_in;
            end else begin : g_body
                assign shift_src = cell_value[g+1];
            end

            stmf_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .cell_idx  (IDX_W'(g)),
                .sample_in (sample_in),
                .shift_in  (shift_src),
                .probe_in  (cell_probe[(g + 1) % WINDOW_SIZE]),
                .value_out (cell_value[g]),
                .probe_out (cell_probe[g])
            );
        end
    endgenerate

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        primed_next    = primed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        acc_next       = acc_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    primed_next = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cnt_next   = '0;
                state_next = ST_RANK;
            end
            ST_RANK: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_MASK;
                end
            end
            ST_MASK: begin
                cnt_next   = '0;
                acc_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // The kept values pass cell zero one per cycle.
                acc_next = acc_reg + ACC_W'(cell_probe[0]);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = saturate(acc_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        acc_reg      <= acc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - OUT_W){1'b0}}, out_data_reg};

    `STMF_ASSERT_NEXT(a_accept_loads, aclk, aresetn, s_accept, (state_reg == ST_LOAD) && primed_reg, "accepted word did not start a ranking pass")
    `STMF_ASSERT_NEXT(a_rank_to_mask, aclk, aresetn, (state_reg == ST_RANK) && cnt_last, state_reg == ST_MASK, "ranking pass did not end after one full rotation")
    `STMF_ASSERT_NEXT(a_done_emits, aclk, aresetn, (state_reg == ST_DONE) && out_free, out_valid_reg && (state_reg == ST_IDLE), "finished sum was not placed in the output register")
    `STMF_ASSERT_SAME(a_no_overwrite, aclk, aresetn, (state_reg == ST_DONE) && out_valid_reg && !m_tready, state_next == ST_DONE, "pending result would be overwritten")

endmodule

>>> tb/tb_sliding_trimmed_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding trimmed mean filter testbench
// Streams signed samples into the filter and checks every trimmed sum against
// a behavioral window kept alongside, under several idle and stall patterns
// and one long output hold-off that backs the filter up.
// ----------------------------------------------------------------------------
module tb_sliding_trimmed_mean_filter;

    import stmf_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 100;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] sample
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [18:0] trimmed_sum, [23:19] zero

    sliding_trimmed_mean_filter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Behavioral copy of the window, oldest sample at index 0.
    sample_t  hist [WINDOW_SIZE];
    bit       hist_primed;
    out_sum_t expected_sums [$];

    int error_count;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_request;
    int hold_left;
    int level;

    initial begin
        aclk = 1'b0;
    end

    always #CLK_HALF aclk = ~aclk;

    function automatic out_sum_t predict_trimmed_sum(input sample_t x);
        int sorted [WINDOW_SIZE];
        int acc;
        int tmp;
        int j;
        for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
            hist[i] = hist[i + 1];
        end
        hist[WINDOW_SIZE - 1] = x;
        if (!hist_primed) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                hist[i] = x;
            end
        end
        hist_primed = 1'b1;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            tmp = hist[i];
            j = i;
            while (j > 0 && sorted[j - 1] > tmp) begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = tmp;
        end
        acc = 0;
        for (int i = KEEP_LO; i < KEEP_HI; i++) begin
            acc += sorted[i];
        end
        if (acc > SUM_MAX) begin
            acc = SUM_MAX;
        end else if (acc < SUM_MIN) begin
            acc = SUM_MIN;
        end
        return out_sum_t'(acc);
    endfunction

    // Mix of raw noise, a slowly drifting sensor level, rail values and a
    // narrow band of small values that produces many ties.
    function automatic sample_t pick_sample();
        int kind;
        int v;
        kind = $urandom_range(9);
        if (kind <= 3) begin
            v = int'($signed(16'($urandom)));
        end else if (kind <= 6) begin
            level += $urandom_range(200) - 100;
            if ($urandom_range(30) == 0) begin
                level = int'($signed(16'($urandom)));
            end
            v = level + $urandom_range(16) - 8;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            level = v;
        end else if (kind == 7) begin
            case ($urandom_range(3))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                default: v = -1;
            endcase
        end else begin
            v = $urandom_range(4) - 2;
        end
        return sample_t'(v);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word
    // has been accepted.
    task automatic send_sample(input sample_t x);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        expected_sums.push_back(predict_trimmed_sum(x));
        @(negedge aclk);
    endtask

    task automatic test_directed();
        sample_t seq [$];
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // The first word fills the whole window at the negative rail, then
        // twelve positive rail words push the kept middle to the top.
        seq.push_back(sample_t'(-32768));
        for (int i = 0; i < 12; i++) begin
            seq.push_back(sample_t'(32767));
        end
        seq.push_back(sample_t'(0));
        seq.push_back(sample_t'(-1));
        seq.push_back(sample_t'(1));
        seq.push_back(sample_t'(16'h5555));
        seq.push_back(sample_t'(16'hAAAA));
        // Repeated equal values: ties among the kept middle entries.
        for (int i = 0; i < 5; i++) begin
            seq.push_back(sample_t'(7));
        end
        foreach (seq[i]) begin
            send_sample(seq[i]);
        end
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            send_sample(pick_sample());
        end
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    // The receiver holds off while the sender keeps offering words, so the
    // output register fills and the input must stall.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 400;
        for (int i = 0; i < 40; i++) begin
            send_sample(pick_sample());
        end
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_sums.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word, expected none, actual %0d",
                         $time, $signed(m_tdata[18:0]));
            end else begin
                out_sum_t want;
                want = expected_sums.pop_front();
                if (m_tdata[18:0] !== want) begin
                    error_count++;
                    $display("%0t: trimmed_sum mismatch, expected %0d, actual %0d",
                             $time, want, $signed(m_tdata[18:0]));
                end
                if (m_tdata[23:19] !== 5'd0) begin
                    error_count++;
                    $display("%0t: padding mismatch, expected 0, actual %0h",
                             $time, m_tdata[23:19]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d sums outstanding", $time, expected_sums.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        m_tready           = 1'b0;
        hist_primed        = 1'b0;
        error_count        = 0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 0;
        hold_left          = 0;
        level              = 0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            hist[i] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random(200, 0, 0);
        test_random(200, 64, 0);
        test_random(200, 0, 64);
        test_random(200, 23, 23);
        test_backpressure();
        test_random(60, 0, 0);

        while (expected_sums.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
